### sv/ifd_pkg.sv
package ifd_pkg;

    localparam int DATA_WIDTH  = 64;
    localparam int FIELD_WIDTH = 64;
    localparam int ETYPE_WIDTH = 3;
    localparam int QDEPTH      = 2;
    localparam int QPTR_WIDTH  = $clog2(QDEPTH);
    localparam int QCNT_WIDTH  = $clog2(QDEPTH + 1);

    typedef logic [ETYPE_WIDTH-1:0] t_etype;

    localparam t_etype ET_INT8   = 3'd0;
    localparam t_etype ET_INT16  = 3'd1;
    localparam t_etype ET_INT32  = 3'd2;
    localparam t_etype ET_INT64  = 3'd3;
    localparam t_etype ET_UINT8  = 3'd4;
    localparam t_etype ET_UINT16 = 3'd5;
    localparam t_etype ET_RESET  = ET_INT32;

    typedef enum logic [1:0] {
        SZ8  = 2'd0,
        SZ16 = 2'd1,
        SZ32 = 2'd2,
        SZ64 = 2'd3
    } t_size;

    typedef logic [DATA_WIDTH-1:0] t_word;

    // one classified item travelling from front to back
    typedef struct packed {
        t_word mag_a;
        t_word mag_b;
        logic  neg;
        logic  zero;
        logic  sgn;
        t_size size;
    } t_item;

    // operand width in bits, clamped to the datapath width
    function automatic int unsigned size_bits(input t_size s);
        int unsigned w;
        case (s)
            SZ8:     w = 8;
            SZ16:    w = 16;
            SZ32:    w = 32;
            SZ64:    w = 64;
            default: w = 64;
        endcase
        if (w > DATA_WIDTH) begin
            w = DATA_WIDTH;
        end
        return w;
    endfunction

    // keep the low bits of the size, sign- or zero-extend above
    function automatic t_word fit(input t_word v, input t_size s, input logic sgn);
        int unsigned w;
        logic        sb;
        t_word       r;
        w  = size_bits(s);
        sb = 1'b0;
        for (int i = 0; i < DATA_WIDTH; i++) begin
            if (i == int'(w) - 1) begin
                sb = v[i];
            end
        end
        for (int i = 0; i < DATA_WIDTH; i++) begin
            r[i] = (i < int'(w)) ? v[i] : (sgn & sb);
        end
        return r;
    endfunction

endpackage

### sv/ifd_front.sv
module ifd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_wdata,
    input  logic [63:0]    i_dividend,
    input  logic [63:0]    i_divisor,
    output ifd_pkg::t_item o_item
);

    ifd_pkg::t_etype r_etype;
    ifd_pkg::t_size  size;
    logic            sgn;
    ifd_pkg::t_word  ext_a;
    ifd_pkg::t_word  ext_b;
    logic            na;
    logic            nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etype <= ifd_pkg::ET_RESET;
        end else if (i_cfg_we) begin
            r_etype <= i_cfg_wdata;
        end
    end

    // decode element type, unknown codes run as int64
    always_comb begin
        case (r_etype)
            ifd_pkg::ET_INT8:   begin size = ifd_pkg::SZ8;  sgn = 1'b1; end
            ifd_pkg::ET_INT16:  begin size = ifd_pkg::SZ16; sgn = 1'b1; end
            ifd_pkg::ET_INT32:  begin size = ifd_pkg::SZ32; sgn = 1'b1; end
            ifd_pkg::ET_UINT8:  begin size = ifd_pkg::SZ8;  sgn = 1'b0; end
            ifd_pkg::ET_UINT16: begin size = ifd_pkg::SZ16; sgn = 1'b0; end
            default:            begin size = ifd_pkg::SZ64; sgn = 1'b1; end
        endcase
    end

    assign ext_a = ifd_pkg::fit(i_dividend[ifd_pkg::DATA_WIDTH-1:0], size, sgn);
    assign ext_b = ifd_pkg::fit(i_divisor[ifd_pkg::DATA_WIDTH-1:0], size, sgn);
    assign na    = sgn & ext_a[ifd_pkg::DATA_WIDTH-1];
    assign nb    = sgn & ext_b[ifd_pkg::DATA_WIDTH-1];

    always_comb begin
        o_item.mag_a = na ? (ifd_pkg::t_word'(0) - ext_a) : ext_a;
        o_item.mag_b = nb ? (ifd_pkg::t_word'(0) - ext_b) : ext_b;
        o_item.neg   = na ^ nb;
        o_item.zero  = (ext_b == '0);
        o_item.sgn   = sgn;
        o_item.size  = size;
    end

endmodule

### sv/ifd_queue.sv
module ifd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ifd_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_pop,
    output ifd_pkg::t_item o_item
);

    ifd_pkg::t_item                      r_mem [ifd_pkg::QDEPTH];
    logic [ifd_pkg::QPTR_WIDTH-1:0]      r_wptr;
    logic [ifd_pkg::QPTR_WIDTH-1:0]      r_rptr;
    logic [ifd_pkg::QCNT_WIDTH-1:0]      r_cnt;
    logic [ifd_pkg::QPTR_WIDTH-1:0]      n_wptr;
    logic [ifd_pkg::QPTR_WIDTH-1:0]      n_rptr;
    logic [ifd_pkg::QCNT_WIDTH-1:0]      n_cnt;

    // back end never stalls, so the head drains every cycle it is there
    assign o_pop  = (r_cnt != '0);
    assign o_full = (r_cnt == ifd_pkg::QCNT_WIDTH'(ifd_pkg::QDEPTH));
    assign o_item = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == ifd_pkg::QPTR_WIDTH'(ifd_pkg::QDEPTH - 1)) ? '0 :
                     r_wptr + ifd_pkg::QPTR_WIDTH'(1);
        end
        if (o_pop) begin
            n_rptr = (r_rptr == ifd_pkg::QPTR_WIDTH'(ifd_pkg::QDEPTH - 1)) ? '0 :
                     r_rptr + ifd_pkg::QPTR_WIDTH'(1);
        end
        if (i_push && !o_pop) begin
            n_cnt = r_cnt + ifd_pkg::QCNT_WIDTH'(1);
        end else if (!i_push && o_pop) begin
            n_cnt = r_cnt - ifd_pkg::QCNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

### sv/ifd_back.sv
module ifd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ifd_pkg::t_item i_item,
    output logic           o_valid,
    output ifd_pkg::t_word o_quotient,
    output logic           o_divide_by_zero
);

    localparam int DW = ifd_pkg::DATA_WIDTH;

    typedef struct packed {
        ifd_pkg::t_word rem;
        ifd_pkg::t_word quo;
        ifd_pkg::t_word mag_b;
        logic           neg;
        logic           zero;
        logic           sgn;
        ifd_pkg::t_size size;
    } t_div;

    // one restoring step: bring down the next dividend bit
    function automatic t_div div_step(input t_div s);
        logic [DW:0]    sh;
        logic [DW:0]    diff;
        t_div           r;
        r    = s;
        sh   = {s.rem, s.quo[DW-1]};
        diff = sh - {1'b0, s.mag_b};
        if (!diff[DW]) begin
            r.rem = diff[DW-1:0];
            r.quo = {s.quo[DW-2:0], 1'b1};
        end else begin
            r.rem = sh[DW-1:0];
            r.quo = {s.quo[DW-2:0], 1'b0};
        end
        return r;
    endfunction

    t_div           r_stg [DW+1];
    logic [DW:0]    r_vld;
    t_div           n_stg [DW+1];
    ifd_pkg::t_word adj;
    ifd_pkg::t_word res;
    ifd_pkg::t_word r_quot;
    logic           r_dz;
    logic           r_out_vld;

    always_comb begin
        n_stg[0].rem   = '0;
        n_stg[0].quo   = i_item.mag_a;
        n_stg[0].mag_b = i_item.mag_b;
        n_stg[0].neg   = i_item.neg;
        n_stg[0].zero  = i_item.zero;
        n_stg[0].sgn   = i_item.sgn;
        n_stg[0].size  = i_item.size;
    end

    for (genvar k = 0; k < DW; k++) begin : g_step
        assign n_stg[k+1] = div_step(r_stg[k]);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DW; k++) begin
            r_stg[k] <= n_stg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[DW-1:0], i_valid};
            r_out_vld <= r_vld[DW];
        end
    end

    // floor fix-up: round magnitude up when signs differ and remainder is left
    always_comb begin
        adj = r_stg[DW].quo + ifd_pkg::t_word'(r_stg[DW].rem != '0);
        res = r_stg[DW].neg ? (ifd_pkg::t_word'(0) - adj) : r_stg[DW].quo;
        res = ifd_pkg::fit(res, r_stg[DW].size, r_stg[DW].sgn);
    end

    always_ff @(posedge i_clk) begin
        r_quot <= r_stg[DW].zero ? '0 : res;
        r_dz   <= r_stg[DW].zero;
    end

    assign o_valid          = r_out_vld;
    assign o_quotient       = r_quot;
    assign o_divide_by_zero = r_dz;

endmodule

### sv/integer_floor_divider_unit.sv
// an accepted start passes the queue, the divider stage registers and the result register before o_valid is high
// throughput: one item per cycle while busy is low, through the DATA_WIDTH-step restoring divider pipeline
// busy stays low in normal use: the back end drains the queue every cycle
// results cannot be stalled; each one is on the ports for one cycle with o_valid
// reset (i_rst_n low, synchronous): queue and pipeline emptied, element type back to int32
module integer_floor_divider_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_valid,
    output logic [63:0] o_quotient,
    output logic        o_divide_by_zero
);

    ifd_pkg::t_item front_item;   // classified operands, combinational from the ports
    ifd_pkg::t_item head_item;    // queue head feeding the divider
    logic           push;         // input transfer
    logic           pop;          // queue head moves into the divider
    logic           full;
    ifd_pkg::t_word quot;

    assign push = start & ~busy;
    assign busy = full;

    // front: element type register, operand extension, sign and zero checks
    ifd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_item      (front_item)
    );

    // short queue decoupling the front from the divider pipeline
    ifd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .o_pop   (pop),
        .o_item  (head_item)
    );

    // back: magnitude division, floor correction, result register
    ifd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (pop),
        .i_item           (head_item),
        .o_valid          (o_valid),
        .o_quotient       (quot),
        .o_divide_by_zero (o_divide_by_zero)
    );

    // quotient is zero-extended from the datapath width
    assign o_quotient = ifd_pkg::FIELD_WIDTH'(quot);

`ifndef SYNTH
    a_queue_never_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !full)
        else $error("item queue filled although the divider drains it every cycle");

    a_result_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(pop, ifd_pkg::DATA_WIDTH + 2))
        else $error("result strobe without a matching queue pop");

    a_zero_divisor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_quotient == '0))
        else $error("zero divisor result carries a nonzero quotient");
`endif

endmodule
